FILE: rtl/core/tdfa_pkg.sv
// Shared types and constants for the table-driven DFA acceptor.
`default_nettype none

package tdfa_pkg;

	// Input item kinds.
	localparam logic [2:0] KIND_CHAR  = 3'd0;
	localparam logic [2:0] KIND_END   = 3'd1;
	localparam logic [2:0] KIND_SYM   = 3'd2;
	localparam logic [2:0] KIND_TRANS = 3'd3;
	localparam logic [2:0] KIND_FLAG  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_START_STATE = 2'd0;
	localparam logic [1:0] CFG_NUM_SYMBOLS = 2'd1;
	localparam logic [1:0] CFG_NUM_STATES  = 2'd2;

	// Configuration reset values.
	localparam logic [6:0] START_STATE_RST = 7'd1;
	localparam logic [4:0] NUM_SYMBOLS_RST = 5'd0;
	localparam logic [6:0] NUM_STATES_RST  = 7'd64;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHAR,
		ST_END
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;      // clearing pass writes one final flag entry
		logic take;       // an input item is accepted this cycle
		logic step_char;  // transition read data is valid, update state
		logic finish_end; // final flag read data is valid, form verdict
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last; // clearing pass is at its last entry
	} dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/table_driven_dfa_acceptor_unit.sv
// Top level of the table-driven DFA acceptor.
//
// For a character item, at the accept edge the byte is matched against all
// alphabet slots in use at once and the transition memory is read, and in the
// following cycle the registered entry becomes the new state. An end item
// reads the final flag memory, then loads the verdict register; load items
// and unused kinds need no further step. An end item waits while an
// earlier verdict has not been taken. After reset the final flag memory is
// cleared one entry per cycle, so input stalls until every entry is cleared;
// configuration writes are taken at any time and cfg_ready is always high.
`default_nettype none

module table_driven_dfa_acceptor_unit #(
	parameter int MAX_STATES  = 64,
	parameter int MAX_SYMBOLS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [6:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        kind,
	input  wire logic [7:0]        char_value,
	input  wire logic [3:0]        slot_index,
	input  wire logic [6:0]        state_index,
	input  wire logic signed [7:0] next_state,
	input  wire logic              flag_value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   accepted
);
	import tdfa_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t sts;
	logic       cfg_we;

	// Every register write is taken at once, so the port never holds off.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	tdfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tdfa_datapath #(
		.MAX_STATES  (MAX_STATES),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.char_value  (char_value),
		.slot_index  (slot_index),
		.state_index (state_index),
		.next_state  (next_state),
		.flag_value  (flag_value),
		.accepted    (accepted)
	);

endmodule

`default_nettype wire

FILE: rtl/core/tdfa_ctrl.sv
// Controller state machine for the DFA acceptor: handshakes and sequencing.
`default_nettype none

module tdfa_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [2:0]          kind,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire tdfa_pkg::dp_status_t sts,
	output tdfa_pkg::ctl_cmd_t       cmd
);
	import tdfa_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       out_valid_q;
	logic       take;

	// An end item needs the output register free; everything else only needs idle.
	assign in_stall  = (state_q != ST_IDLE) || ((kind == KIND_END) && out_valid_q);
	assign take      = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_END) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d        = state_q;
		cmd.clear      = 1'b0;
		cmd.take       = 1'b0;
		cmd.step_char  = 1'b0;
		cmd.finish_end = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.take = take;
				if (take && (kind == KIND_CHAR)) begin
					state_d = ST_CHAR;
				end else if (take && (kind == KIND_END)) begin
					state_d = ST_END;
				end
			end
			ST_CHAR: begin
				cmd.step_char = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_END: begin
				cmd.finish_end = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/tdfa_datapath.sv
// Datapath of the DFA acceptor: tables, symbol match, state and verdict.
`default_nettype none

module tdfa_datapath #(
	parameter int MAX_STATES  = 64,
	parameter int MAX_SYMBOLS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tdfa_pkg::ctl_cmd_t  cmd,
	output tdfa_pkg::dp_status_t     sts,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [6:0]          cfg_data,
	input  wire logic [2:0]          kind,
	input  wire logic [7:0]          char_value,
	input  wire logic [3:0]          slot_index,
	input  wire logic [6:0]          state_index,
	input  wire logic signed [7:0]   next_state,
	input  wire logic                flag_value,
	output logic                     accepted
);
	import tdfa_pkg::*;

	localparam int STATE_W     = $clog2(MAX_STATES);
	localparam int SLOT_W      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int IW          = ((STATE_W > 7) ? STATE_W : 7) + 1;
	localparam int TRANS_DEPTH = MAX_STATES * (2 ** SLOT_W);
	localparam int ADDR_W      = STATE_W + SLOT_W;

	// Configuration registers.
	logic [6:0] start_q;
	logic [4:0] nsym_q;
	logic [6:0] nstates_q;

	// String state.
	logic [6:0] cur_q;
	logic       rej_q;
	logic       step_live_q;
	logic       end_ok_q;
	logic       accepted_q;

	// Tables.
	logic [7:0] sym_q [MAX_SYMBOLS];
	logic [7:0] trans_mem [TRANS_DEPTH];
	logic       flag_mem [MAX_STATES];
	logic [7:0] trans_rd_q;
	logic       flag_rd_q;

	// Clearing pass over the final flags.
	logic [STATE_W-1:0] clr_cnt_q;

	logic               found;
	logic [SLOT_W-1:0]  slot_sel;
	logic [IW-1:0]      cur_m1;
	logic [IW-1:0]      st_m1;
	logic               cur_ok;
	logic               rd_ok;
	logic               load_slot_ok;
	logic               load_state_ok;
	logic [ADDR_W-1:0]  trans_wr_addr;
	logic [ADDR_W-1:0]  trans_rd_addr;

	// A state is live when it is nonzero and within both the used and built counts.
	function automatic logic state_ok(input logic [7:0] s, input logic [6:0] n);
		return (s != 8'd0) && (s <= {1'b0, n}) && (int'(s) <= MAX_STATES);
	endfunction

	assign cur_ok = state_ok({1'b0, cur_q}, nstates_q);
	assign rd_ok  = state_ok(trans_rd_q, nstates_q);
	assign cur_m1 = IW'(cur_q) - IW'(1);
	assign st_m1  = IW'(state_index) - IW'(1);

	assign load_slot_ok  = int'(slot_index) < MAX_SYMBOLS;
	assign load_state_ok = (state_index != 7'd0) && (int'(state_index) <= MAX_STATES);

	assign trans_wr_addr = {st_m1[STATE_W-1:0], SLOT_W'(slot_index)};
	assign trans_rd_addr = {cur_m1[STATE_W-1:0], slot_sel};

	assign sts.clear_last = (clr_cnt_q == STATE_W'(MAX_STATES - 1));
	assign accepted       = accepted_q;

	// Parallel symbol match; the lowest matching slot in use wins.
	always_comb begin
		found    = 1'b0;
		slot_sel = '0;
		for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
			if ((sym_q[i] == char_value) && (i < int'(nsym_q))) begin
				found    = 1'b1;
				slot_sel = SLOT_W'(i);
			end
		end
	end

	// Alphabet slots.
	always_ff @(posedge clk) begin
		if (cmd.take && (kind == KIND_SYM) && load_slot_ok) begin
			sym_q[SLOT_W'(slot_index)] <= char_value;
		end
	end

	// Transition memory: one port, a load writes and a character reads.
	always_ff @(posedge clk) begin
		if (cmd.take && (kind == KIND_TRANS) && load_slot_ok && load_state_ok) begin
			trans_mem[trans_wr_addr] <= next_state;
		end else if (cmd.take && (kind == KIND_CHAR)) begin
			trans_rd_q <= trans_mem[trans_rd_addr];
		end
	end

	// Final flag memory: cleared after reset, then loaded and read at end items.
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			flag_mem[clr_cnt_q] <= 1'b0;
		end else if (cmd.take && (kind == KIND_FLAG) && load_state_ok) begin
			flag_mem[st_m1[STATE_W-1:0]] <= flag_value;
		end else if (cmd.take && (kind == KIND_END)) begin
			flag_rd_q <= flag_mem[cur_m1[STATE_W-1:0]];
		end
	end

	// Clearing pass address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear && !sts.clear_last) begin
			clr_cnt_q <= clr_cnt_q + STATE_W'(1);
		end
	end

	// Verdict register.
	always_ff @(posedge clk) begin
		if (cmd.finish_end) begin
			accepted_q <= end_ok_q & flag_rd_q;
		end
	end

	// Configuration and string state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= START_STATE_RST;
			nsym_q      <= NUM_SYMBOLS_RST;
			nstates_q   <= NUM_STATES_RST;
			cur_q       <= START_STATE_RST;
			rej_q       <= 1'b0;
			step_live_q <= 1'b0;
			end_ok_q    <= 1'b0;
		end else begin
			// A character item checks the match and current state at accept.
			if (cmd.take && (kind == KIND_CHAR)) begin
				step_live_q <= !rej_q && found && cur_ok;
				if (!rej_q && !(found && cur_ok)) begin
					rej_q <= 1'b1;
				end
			end
			if (cmd.take && (kind == KIND_END)) begin
				end_ok_q <= !rej_q && cur_ok;
			end
			// In the following cycle the transition target is checked and taken.
			if (cmd.step_char && step_live_q) begin
				if (rd_ok) begin
					cur_q <= trans_rd_q[6:0];
				end else begin
					rej_q <= 1'b1;
				end
			end
			// The end of a string returns to the start state.
			if (cmd.finish_end) begin
				cur_q <= start_q;
				rej_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_STATE: begin
						start_q <= cfg_data;
						cur_q   <= cfg_data;
						rej_q   <= 1'b0;
					end
					CFG_NUM_SYMBOLS: begin
						nsym_q <= cfg_data[4:0];
					end
					CFG_NUM_STATES: begin
						nstates_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/tdfa_port_checker.sv
// Port-level checks for the DFA acceptor and their binding to the top level.
`default_nettype none

module tdfa_port_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [2:0]        kind,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              accepted
);
	import tdfa_pkg::*;

	// A stalled verdict stays and holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted))
		else $error("verdict dropped or changed while stalled");

	// A new verdict rises only after an accepted end item has passed through the end state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && (kind == KIND_END), 2))
		else $error("verdict without a matching end item");

	// An end item is never taken while an earlier verdict still waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == KIND_END) |-> !out_valid)
		else $error("end item accepted over a waiting verdict");

	// A character item holds off input for its transition read cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == KIND_CHAR) |=> in_stall)
		else $error("input taken during a character step");

endmodule

bind table_driven_dfa_acceptor_unit tdfa_port_checker u_port_checker (.*);

`default_nettype wire

FILE: tb/sv/tdfa_checker.sv
// Checker for the DFA acceptor: tracks the automaton on accepted items and compares verdicts.
module tdfa_checker #(
	parameter int MAX_STATES  = 64,
	parameter int MAX_SYMBOLS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [2:0]        kind,
	input  logic [7:0]        char_value,
	input  logic [3:0]        slot_index,
	input  logic [6:0]        state_index,
	input  logic signed [7:0] next_state,
	input  logic              flag_value,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              accepted,
	output int                mismatch_count,
	output int                verdicts_due
);
	import tdfa_pkg::*;

	// Shadow copy of the configuration registers.
	logic [6:0] start_q;
	logic [4:0] nsym_q;
	logic [6:0] nstates_q;

	// Shadow copy of the automaton and its tables.
	logic [6:0] cur_q;
	logic       dead_q;
	logic [7:0] sym_tab [MAX_SYMBOLS];
	logic [7:0] trans_tab [MAX_STATES * MAX_SYMBOLS];
	logic       flag_tab [MAX_STATES];

	// Verdicts still owed by the block, oldest first.
	bit verdict_q [$];

	// A state is live when it lies in 1 .. states in use, capped at MAX_STATES.
	function automatic bit state_live(input int s);
		int lim;
		lim = (nstates_q > MAX_STATES) ? MAX_STATES : int'(nstates_q);
		return (s >= 1) && (s <= lim);
	endfunction

	// Advance the automaton by one string byte.
	task automatic take_char(input logic [7:0] c);
		int n;
		int slot;
		bit hit;
		logic [7:0] nxt;
		n = (nsym_q > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(nsym_q);
		hit = 1'b0;
		slot = 0;
		if (dead_q)
			return;
		// Walk downward so the lowest matching slot wins.
		for (int i = n - 1; i >= 0; i--) begin
			if (sym_tab[i] == c) begin
				hit = 1'b1;
				slot = i;
			end
		end
		if (!hit || !state_live(cur_q)) begin
			dead_q = 1'b1;
			return;
		end
		nxt = trans_tab[(int'(cur_q) - 1) * MAX_SYMBOLS + slot];
		if (nxt[7] || !state_live(int'(nxt))) begin
			dead_q = 1'b1;
			return;
		end
		cur_q = nxt[6:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		bit want;
		if (!arst_n) begin
			start_q = START_STATE_RST;
			nsym_q = NUM_SYMBOLS_RST;
			nstates_q = NUM_STATES_RST;
			cur_q = START_STATE_RST;
			dead_q = 1'b0;
			for (int i = 0; i < MAX_STATES; i++)
				flag_tab[i] = 1'b0;
			verdict_q.delete();
			mismatch_count = 0;
		end else begin
			// Compare each verdict taken from the block with the oldest one owed.
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("accepted: expected none, actual %0b", accepted);
					mismatch_count++;
				end else begin
					want = verdict_q.pop_front();
					if (accepted !== want) begin
						$error("accepted: expected %0b, actual %0b", want, accepted);
						mismatch_count++;
					end
				end
			end

			// Register writes; a start state write restarts the current string.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_STATE: begin
						start_q = cfg_data;
						cur_q = cfg_data;
						dead_q = 1'b0;
					end
					CFG_NUM_SYMBOLS: nsym_q = cfg_data[4:0];
					CFG_NUM_STATES: nstates_q = cfg_data;
					default: ;
				endcase
			end

			// Apply the accepted input item.
			if (in_valid && !in_stall) begin
				case (kind)
					KIND_CHAR: take_char(char_value);
					KIND_END: begin
						want = !dead_q && state_live(cur_q) ? flag_tab[cur_q - 1] : 1'b0;
						verdict_q.push_back(want);
						cur_q = start_q;
						dead_q = 1'b0;
					end
					KIND_SYM: begin
						if (slot_index < MAX_SYMBOLS)
							sym_tab[slot_index] = char_value;
					end
					KIND_TRANS: begin
						if (slot_index < MAX_SYMBOLS && state_index >= 1 &&
								state_index <= MAX_STATES)
							trans_tab[(int'(state_index) - 1) * MAX_SYMBOLS + slot_index] =
								next_state;
					end
					KIND_FLAG: begin
						if (state_index >= 1 && state_index <= MAX_STATES)
							flag_tab[state_index - 1] = flag_value;
					end
					default: ;
				endcase
			end
		end
		verdicts_due = verdict_q.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the DFA acceptor: clock, reset, stimulus and the final verdict.
module tb_top;
	import tdfa_pkg::*;

	localparam int         HUB_ROWS          = 6;
	localparam logic [6:0] TOP_ROW           = 7'd64;
	localparam logic [7:0] NO_EDGE           = 8'hFF;
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
	localparam int         PHASE_ITEMS       = 45;
	localparam int         NUM_PHASES        = 6;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index   = CFG_START_STATE;
	logic [6:0]        cfg_data    = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [2:0]        kind        = KIND_CHAR;
	logic [7:0]        char_value  = '0;
	logic [3:0]        slot_index  = '0;
	logic [6:0]        state_index = '0;
	logic signed [7:0] next_state  = '0;
	logic              flag_value  = 1'b0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              accepted;

	int mismatches;
	int verdicts_due;

	// Bytes written to each alphabet slot, used to build strings that get somewhere.
	logic [7:0] sym_bytes [16];
	int sym_used   = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int item_count = 0;

	table_driven_dfa_acceptor_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.char_value (char_value),
		.slot_index (slot_index),
		.state_index(state_index),
		.next_state (next_state),
		.flag_value (flag_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted)
	);

	tdfa_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.char_value    (char_value),
		.slot_index    (slot_index),
		.state_index   (state_index),
		.next_state    (next_state),
		.flag_value    (flag_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.mismatch_count(mismatches),
		.verdicts_due  (verdicts_due)
	);

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side stalls in stretches: none, random, or stalled except when the countdown is a multiple of four.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(16, 64);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom);
			default: out_stall <= (stall_left % 4) != 0;
		endcase
	end

	// Safety net against a hung block.
	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	// Rows that strings may reach: the first few states and the highest one.
	function automatic logic [6:0] pick_row();
		int r;
		r = $urandom_range(0, HUB_ROWS);
		return (r == HUB_ROWS) ? TOP_ROW : 7'(r + 1);
	endfunction

	// Targets are reachable rows, or ones that reject under every state count.
	function automatic logic [7:0] pick_target();
		case ($urandom_range(0, 9))
			0: return NO_EDGE;
			1: return 8'($urandom_range(128, 254));
			2: return 8'd0;
			3: return 8'($urandom_range(65, 127));
			4: return 8'(TOP_ROW);
			default: return 8'($urandom_range(1, HUB_ROWS));
		endcase
	endfunction

	// Present one item and hold it until taken; the sender works in bursts.
	task automatic put_item(input logic [2:0] k, input logic [7:0] ch, input logic [3:0] sl,
			input logic [6:0] st, input logic [7:0] nx, input logic fl);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		kind <= k;
		char_value <= ch;
		slot_index <= sl;
		state_index <= st;
		next_state <= nx;
		flag_value <= fl;
		in_valid <= 1'b1;
		if (k == KIND_SYM)
			sym_bytes[sl] = ch;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		item_count++;
		burst_left--;
		if (burst_left == 0)
			in_valid <= 1'b0;
	endtask

	// Drop valid and wait until every verdict is in and the block has gone quiet.
	task automatic settle();
		if (burst_left != 0) begin
			in_valid <= 1'b0;
			burst_left = 0;
		end
		while (verdicts_due != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [6:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		if (idx == CFG_NUM_SYMBOLS)
			sym_used = (d[4:0] > 16) ? 16 : int'(d[4:0]);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// One table update or an unused kind, with random content.
	task automatic random_load();
		case ($urandom_range(0, 4))
			0: put_item(KIND_SYM, 8'($urandom), 4'($urandom), 7'($urandom), 8'($urandom),
				1'($urandom));
			1, 2: put_item(KIND_TRANS, 8'($urandom), 4'($urandom),
				($urandom_range(0, 3) == 0) ? 7'($urandom) : pick_row(), pick_target(),
				1'($urandom));
			3: put_item(KIND_FLAG, 8'($urandom), 4'($urandom),
				($urandom_range(0, 3) == 0) ? 7'($urandom) : pick_row(), 8'($urandom),
				1'($urandom));
			default: put_item(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
				8'($urandom), 4'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
		endcase
	endtask

	// A string of mostly known bytes, sometimes with loads in between, then its end item.
	task automatic play_string();
		int len;
		logic [7:0] b;
		len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				random_load();
			if (sym_used != 0 && $urandom_range(0, 9) != 0)
				b = sym_bytes[$urandom_range(0, sym_used - 1)];
			else
				b = 8'($urandom);
			put_item(KIND_CHAR, b, 4'($urandom), 7'($urandom), 8'($urandom), 1'($urandom));
		end
		put_item(KIND_END, 8'($urandom), 4'($urandom), 7'($urandom), 8'($urandom),
			1'($urandom));
	endtask

	initial begin
		logic [6:0] ph_start;
		logic [6:0] ph_states;
		logic [6:0] ph_syms;
		logic [6:0] row;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty string after reset: the flag store is clear, so it is rejected.
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		// No alphabet slots in use yet, so any byte is unknown.
		put_item(KIND_CHAR, 8'hFF, 4'd15, 7'd127, 8'h7F, 1'b1);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		// Flag writes to states 0 and 65 are ignored; state 1 becomes final.
		put_item(KIND_FLAG, 8'h00, 4'd0, 7'd0, 8'h00, 1'b1);
		put_item(KIND_FLAG, 8'h00, 4'd0, 7'd65, 8'h00, 1'b1);
		put_item(KIND_FLAG, 8'h00, 4'd0, 7'd1, 8'h00, 1'b1);
		// Transition writes to rows 0 and 127 are ignored.
		put_item(KIND_TRANS, 8'h00, 4'd15, 7'd0, 8'd2, 1'b0);
		put_item(KIND_TRANS, 8'h00, 4'd0, 7'd127, 8'd2, 1'b0);
		for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
			put_item(3'(k), 8'($urandom), 4'($urandom), 7'($urandom), 8'($urandom),
				1'($urandom));
		// Empty string from a final start state is accepted.
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);

		// Fill the alphabet, with a repeated byte in slots 5 and 9, and every reachable row.
		for (int i = 0; i < 16; i++)
			put_item(KIND_SYM, 8'($urandom_range(1, 254)), 4'(i), 7'($urandom), 8'($urandom),
				1'($urandom));
		put_item(KIND_SYM, sym_bytes[5], 4'd9, 7'd0, 8'h00, 1'b0);
		for (int r = 0; r <= HUB_ROWS; r++) begin
			row = (r == HUB_ROWS) ? TOP_ROW : 7'(r + 1);
			for (int c = 0; c < 16; c++)
				put_item(KIND_TRANS, 8'($urandom), 4'(c), row, pick_target(), 1'($urandom));
			put_item(KIND_FLAG, 8'($urandom), 4'($urandom), row, 8'($urandom), 1'($urandom));
		end
		settle();
		cfg_write(CFG_NUM_SYMBOLS, 7'd16);

		// Slot 5 leads to final state 2, slot 9 to non-final 3; slot 2 has no edge.
		put_item(KIND_TRANS, 8'h00, 4'd5, 7'd1, 8'd2, 1'b0);
		put_item(KIND_TRANS, 8'h00, 4'd9, 7'd1, 8'd3, 1'b0);
		put_item(KIND_FLAG, 8'h00, 4'd0, 7'd2, 8'h00, 1'b1);
		put_item(KIND_FLAG, 8'h00, 4'd0, 7'd3, 8'h00, 1'b0);
		put_item(KIND_TRANS, 8'h00, 4'd2, 7'd1, NO_EDGE, 1'b0);
		put_item(KIND_TRANS, 8'h00, 4'd3, 7'd1, 8'd65, 1'b0);
		// The shared byte must resolve to the lower slot and accept.
		put_item(KIND_CHAR, sym_bytes[5], 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		// Unknown byte, missing edge, and a target past the state range.
		put_item(KIND_CHAR, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_CHAR, sym_bytes[2], 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_CHAR, sym_bytes[3], 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		// A rejected string ignores the bytes that follow.
		put_item(KIND_CHAR, sym_bytes[2], 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_CHAR, sym_bytes[5], 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		// Writing the start state throws away the string in progress.
		put_item(KIND_CHAR, sym_bytes[9], 4'd0, 7'd0, 8'h00, 1'b0);
		settle();
		cfg_write(CFG_START_STATE, 7'd1);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);
		// With one state in use, the edge to state 2 leaves the range.
		settle();
		cfg_write(CFG_NUM_STATES, 7'd1);
		put_item(KIND_CHAR, sym_bytes[5], 4'd0, 7'd0, 8'h00, 1'b0);
		put_item(KIND_END, 8'h00, 4'd0, 7'd0, 8'h00, 1'b0);

		// Random phases, each under its own register settings.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: begin ph_start = 7'd1;  ph_syms = 7'd16; ph_states = 7'd64;  end
				1: begin ph_start = 7'd64; ph_syms = 7'd31; ph_states = 7'd8;   end
				2: begin ph_start = 7'd3;  ph_syms = 7'd1;  ph_states = 7'd127; end
				3: begin ph_start = 7'd64; ph_syms = 7'd8;  ph_states = 7'd64;  end
				4: begin ph_start = 7'd6;  ph_syms = 7'd17; ph_states = 7'd1;   end
				default: begin ph_start = 7'd2; ph_syms = 7'd16; ph_states = 7'd6; end
			endcase
			cfg_write(CFG_NUM_STATES, ph_states);
			cfg_write(CFG_NUM_SYMBOLS, ph_syms);
			cfg_write(CFG_START_STATE, ph_start);
			item_count = 0;
			while (item_count < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					random_load();
				else
					play_string();
			end
		end

		settle();
		if (mismatches == 0 && verdicts_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/tdfa_pkg.sv
rtl/core/tdfa_ctrl.sv
rtl/core/tdfa_datapath.sv
rtl/core/table_driven_dfa_acceptor_unit.sv
rtl/core/tdfa_port_checker.sv
tb/sv/tdfa_checker.sv
tb/sv/tb_top.sv
